// ===== rtl/core/leb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

  // command codes carried on the kind field
  localparam int unsigned KindW = 3;
  localparam logic [KindW-1:0] KindInsert    = 3'd0;
  localparam logic [KindW-1:0] KindBackspace = 3'd1;
  localparam logic [KindW-1:0] KindDelete    = 3'd2;
  localparam logic [KindW-1:0] KindMove      = 3'd3;
  localparam logic [KindW-1:0] KindGet       = 3'd4;

  localparam int unsigned CharW = 8;
  localparam int unsigned StepW = 8;
  localparam int unsigned PosOutW = 7;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the incoming command
    logic start;     // evaluate command, arm the shift or issue the get read
    logic shift_en;  // move one character per cycle
    logic commit;    // update cursor and length, load the result register
  } leb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_shift;
    logic shift_busy;
  } leb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/leb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module leb_ctrl
  import leb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire leb_stat_t stat_i,
  output leb_cmd_t       cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StExec  = 2'd1;
  localparam logic [1:0] StShift = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && (state_q == StIdle);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        cmd_o.start = 1'b1;
        state_d     = stat_i.need_shift ? StShift : StDone;
      end
      StShift: begin
        cmd_o.shift_en = 1'b1;
        if (!stat_i.shift_busy) state_d = StDone;
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/leb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module leb_datapath
  import leb_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire leb_cmd_t                cmd_i,
  output leb_stat_t                    stat_o,
  input  wire logic [KindW-1:0]        kind_i,
  input  wire logic [CharW-1:0]        char_in_i,
  input  wire logic signed [StepW-1:0] step_i,
  output logic                         ok_o,
  output logic [CharW-1:0]             char_out_o,
  output logic [PosOutW-1:0]           cursor_o,
  output logic [PosOutW-1:0]           length_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned TW = PW + StepW;

  logic [KindW-1:0]        kind_q;
  logic [CharW-1:0]        char_q;
  logic signed [StepW-1:0] step_q;

  logic [PW-1:0] cursor_q, cursor_d;
  logic [PW-1:0] len_q, len_d;
  logic [PW-1:0] src_q, src_d;
  logic [PW-1:0] dst_q, dst_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;

  logic [CharW-1:0] mem [CAPACITY];
  logic [CharW-1:0] rdata_q;
  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  logic [CharW-1:0] wdata;

  logic                 full, ins_ok, bs_ok, del_ok, move_ok, op_ok, shifting_kind;
  logic signed [TW-1:0] target;
  logic [PW-1:0]        move_pos;
  logic                 res_ok;
  logic [CharW-1:0]     res_char;

  // command checks, all taken from the state before the command
  assign full   = (len_q == PW'(CAPACITY));
  assign ins_ok = (char_q != '0) && !full;
  assign bs_ok  = (cursor_q != '0);
  assign del_ok = (cursor_q != len_q);

  assign target = $signed({{StepW{1'b0}}, cursor_q}) + $signed({{PW{step_q[StepW-1]}}, step_q});

  always_comb begin
    move_ok  = 1'b0;
    move_pos = target[PW-1:0];
    if (target[TW-1]) begin
      move_pos = '0;
    end else if (target > $signed({{StepW{1'b0}}, len_q})) begin
      move_pos = len_q;
    end else begin
      move_ok = 1'b1;
    end
  end

  always_comb begin
    op_ok         = 1'b0;
    shifting_kind = 1'b0;
    unique case (kind_q) inside
      KindInsert: begin
        op_ok         = ins_ok;
        shifting_kind = 1'b1;
      end
      KindBackspace, KindDelete: begin
        op_ok         = (kind_q == KindBackspace) ? bs_ok : del_ok;
        shifting_kind = 1'b1;
      end
      KindMove: op_ok = move_ok;
      KindGet:  op_ok = del_ok;
      default:  op_ok = 1'b0;
    endcase
  end

  assign stat_o.need_shift = op_ok && shifting_kind;
  assign stat_o.shift_busy = (cnt_q != '0) || pend_q;

  // shift sequencer: read one entry per cycle, write it one place over next cycle
  always_comb begin
    src_d  = src_q;
    dst_d  = dst_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    if (cmd_i.start) begin
      pend_d = 1'b0;
      cnt_d  = '0;
      if (stat_o.need_shift) begin
        if (kind_q == KindInsert) begin
          src_d = len_q - PW'(1);
          cnt_d = len_q - cursor_q;
        end else if (kind_q == KindBackspace) begin
          src_d = cursor_q;
          cnt_d = len_q - cursor_q;
        end else begin
          src_d = cursor_q + PW'(1);
          cnt_d = len_q - cursor_q - PW'(1);
        end
      end
    end else if (cmd_i.shift_en) begin
      pend_d = (cnt_q != '0);
      if (cnt_q != '0) begin
        cnt_d = cnt_q - PW'(1);
        if (kind_q == KindInsert) begin
          dst_d = src_q + PW'(1);
          src_d = src_q - PW'(1);
        end else begin
          dst_d = src_q - PW'(1);
          src_d = src_q + PW'(1);
        end
      end
    end
  end

  // single memory port pair
  always_comb begin
    re    = 1'b0;
    raddr = src_q[AW-1:0];
    if (cmd_i.start && (kind_q == KindGet) && del_ok) begin
      re    = 1'b1;
      raddr = cursor_q[AW-1:0];
    end else if (cmd_i.shift_en && (cnt_q != '0)) begin
      re = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = dst_q[AW-1:0];
    wdata = rdata_q;
    if (cmd_i.shift_en && pend_q) begin
      we = 1'b1;
    end else if (cmd_i.commit && (kind_q == KindInsert) && ins_ok) begin
      we    = 1'b1;
      waddr = cursor_q[AW-1:0];
      wdata = char_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // commit
  always_comb begin
    cursor_d = cursor_q;
    len_d    = len_q;
    res_ok   = op_ok;
    res_char = '0;
    unique case (kind_q)
      KindInsert: begin
        if (ins_ok) begin
          cursor_d = cursor_q + PW'(1);
          len_d    = len_q + PW'(1);
        end
      end
      KindBackspace: begin
        if (bs_ok) begin
          cursor_d = cursor_q - PW'(1);
          len_d    = len_q - PW'(1);
        end
      end
      KindDelete: begin
        if (del_ok) len_d = len_q - PW'(1);
      end
      KindMove: cursor_d = move_pos;
      KindGet: begin
        if (del_ok) begin
          cursor_d = cursor_q + PW'(1);
          res_char = rdata_q;
        end
      end
      default: res_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      if (cmd_i.commit) begin
        cursor_q <= cursor_d;
        len_q    <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
    if (cmd_i.load) begin
      kind_q <= kind_i;
      char_q <= char_in_i;
      step_q <= step_i;
    end
    if (cmd_i.commit) begin
      ok_o       <= res_ok;
      char_out_o <= res_char;
      cursor_o   <= PosOutW'(cursor_d);
      length_o   <= PosOutW'(len_d);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/line_edit_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                fields
// command   in         in_valid_i / in_ready_o  kind_i, char_in_i, step_i
// result    out        out_valid_o / out_ready_i ok_o, char_out_o, cursor_o, length_o
//
// a command passes through accept, evaluate and commit; when an insert, backspace or delete
// succeeds, a shift phase runs between evaluate and commit, even if no characters move;
// the text memory moves one character per cycle in the shift phase
// reset clears cursor, length and control; the text memory itself is never cleared
// the result register holds a finished result while the next command is accepted;
// a command only waits at its commit cycle while the previous result is still untaken

module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [KindW-1:0]        kind_i,
  input  wire logic [CharW-1:0]        char_in_i,
  input  wire logic signed [StepW-1:0] step_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         ok_o,
  output logic [CharW-1:0]             char_out_o,
  output logic [PosOutW-1:0]           cursor_o,
  output logic [PosOutW-1:0]           length_o
);

  leb_cmd_t  cmd;
  leb_stat_t stat;

  // sequencing: idle, evaluate, shift, commit
  leb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // text memory, cursor, length and result register
  leb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .kind_i     (kind_i),
    .char_in_i  (char_in_i),
    .step_i     (step_i),
    .ok_o       (ok_o),
    .char_out_o (char_out_o),
    .cursor_o   (cursor_o),
    .length_o   (length_o)
  );

  // only one command in flight after a command transfer
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command accepted while another is in flight");

  // commit never overwrites an untaken result
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  // a new result only appears after a commit
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result without commit");

  // the controller returns to idle right after committing
  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> in_ready_o)
    else $error("not idle after commit");

endmodule

`default_nettype wire

// ===== verif/tb_line_edit_buffer.sv =====
`timescale 1ns / 1ps

module tb_line_edit_buffer;
  import leb_pkg::*;

  localparam int unsigned Capacity = 64;
  localparam int unsigned RandItems = 1900;

  // kind codes that the block must ignore
  localparam logic [KindW-1:0] KindSpareA = 3'd5;
  localparam logic [KindW-1:0] KindSpareB = 3'd6;
  localparam logic [KindW-1:0] KindSpareC = 3'd7;

  // one result transfer, field by field
  typedef struct packed {
    logic               ok;
    logic [CharW-1:0]   ch;
    logic [PosOutW-1:0] cur;
    logic [PosOutW-1:0] len;
  } edit_res_t;

  // one directed row: command, repeat count, and a hand-written result where obvious
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] ch;
    logic [StepW-1:0] step;
    logic [7:0]       reps;
    logic             typed;
    edit_res_t        want;
  } dir_row_t;

  localparam int unsigned NumRows = 25;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [KindW-1:0]        kind_i = '0;
  logic [CharW-1:0]        char_in_i = '0;
  logic signed [StepW-1:0] step_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    ok_o;
  logic [CharW-1:0]        char_out_o;
  logic [PosOutW-1:0]      cursor_o;
  logic [PosOutW-1:0]      length_o;

  line_edit_buffer #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .char_in_i  (char_in_i),
    .step_i     (step_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ok_o       (ok_o),
    .char_out_o (char_out_o),
    .cursor_o   (cursor_o),
    .length_o   (length_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the line, the cursor and the length
  logic [CharW-1:0] line_txt [Capacity];
  int               line_cur = 0;
  int               line_len = 0;

  // results still owed by the block, oldest first
  edit_res_t due_results [$];

  int mism_cnt = 0;
  int res_taken = 0;
  int burst_left = 1;

  edit_res_t got_res;
  edit_res_t want_res;

  // directed table; typed rows carry results that follow directly from the command set
  dir_row_t dir_tab [NumRows] = '{
    // empty line: every command but insert at its boundary
    '{KindGet,       8'h00, 8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd0}},
    '{KindBackspace, 8'h00, 8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd0}},
    '{KindDelete,    8'h00, 8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd0}},
    '{KindMove,      8'h00, 8'h40, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd0}},
    '{KindMove,      8'h00, 8'hC0, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd0}},
    '{KindMove,      8'h00, 8'h00, 8'd1,  1'b1, '{1'b1, 8'h00, 7'd0, 7'd0}},
    // character zero is refused so that it keeps meaning end of line
    '{KindInsert,    8'h00, 8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd0}},
    '{KindInsert,    8'hFF, 8'h00, 8'd1,  1'b1, '{1'b1, 8'h00, 7'd1, 7'd1}},
    '{KindInsert,    8'h01, 8'h00, 8'd1,  1'b1, '{1'b1, 8'h00, 7'd2, 7'd2}},
    // most negative step clamps to the start
    '{KindMove,      8'h00, 8'h80, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd0, 7'd2}},
    '{KindGet,       8'h00, 8'h00, 8'd1,  1'b1, '{1'b1, 8'hFF, 7'd1, 7'd2}},
    '{KindGet,       8'h00, 8'h00, 8'd1,  1'b1, '{1'b1, 8'h01, 7'd2, 7'd2}},
    '{KindGet,       8'h00, 8'h00, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd2, 7'd2}},
    '{KindMove,      8'h00, 8'h7F, 8'd1,  1'b1, '{1'b0, 8'h00, 7'd2, 7'd2}},
    // edits in the middle of the line
    '{KindMove,      8'h00, 8'hFF, 8'd1,  1'b0, '0},
    '{KindInsert,    8'h80, 8'h00, 8'd1,  1'b0, '0},
    '{KindBackspace, 8'h00, 8'h00, 8'd1,  1'b0, '0},
    '{KindDelete,    8'h00, 8'h00, 8'd1,  1'b0, '0},
    '{KindSpareA,    8'h7E, 8'h11, 8'd1,  1'b0, '0},
    '{KindSpareB,    8'h00, 8'h00, 8'd1,  1'b0, '0},
    '{KindSpareC,    8'hFF, 8'hFF, 8'd1,  1'b0, '0},
    // fill from the start so every insert shifts the whole tail, then overflow
    '{KindMove,      8'h00, 8'hC0, 8'd1,  1'b0, '0},
    '{KindInsert,    8'hAA, 8'h00, 8'd64, 1'b0, '0},
    '{KindInsert,    8'h55, 8'h00, 8'd1,  1'b0, '0},
    '{KindBackspace, 8'h00, 8'h00, 8'd1,  1'b0, '0}
  };

  // work out the result of one command and advance the shadow line
  task automatic apply_edit(input logic [KindW-1:0] k, input logic [CharW-1:0] c,
                            input logic signed [StepW-1:0] s, output edit_res_t r);
    int tgt;
    int j;
    r = '0;
    case (k)
      KindInsert: begin
        if (c != 8'h00 && line_len < Capacity) begin
          for (j = line_len; j > line_cur; j--) line_txt[j] = line_txt[j-1];
          line_txt[line_cur] = c;
          line_cur++;
          line_len++;
          r.ok = 1'b1;
        end
      end
      KindBackspace, KindDelete: begin
        if (k == KindBackspace ? line_cur > 0 : line_cur < line_len) begin
          if (k == KindBackspace) line_cur--;
          // close the gap left by the removed character
          for (j = line_cur; j + 1 < line_len; j++) line_txt[j] = line_txt[j+1];
          line_len--;
          r.ok = 1'b1;
        end
      end
      KindMove: begin
        tgt = line_cur + int'(s);
        if (tgt < 0) begin
          line_cur = 0;
        end else if (tgt > line_len) begin
          line_cur = line_len;
        end else begin
          line_cur = tgt;
          r.ok = 1'b1;
        end
      end
      KindGet: begin
        if (line_cur < line_len) begin
          r.ch = line_txt[line_cur];
          line_cur++;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.cur = PosOutW'(line_cur);
    r.len = PosOutW'(line_len);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mism_cnt++;
    if (mism_cnt <= 40) begin
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  // offer one command and hold it until the transfer; bursts end in a random gap
  task automatic send_cmd(input logic [KindW-1:0] k, input logic [CharW-1:0] c,
                          input logic [StepW-1:0] s, input logic typed, input edit_res_t want);
    edit_res_t pred;
    int gap;
    in_valid_i <= 1'b1;
    kind_i <= k;
    char_in_i <= c;
    step_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_edit(k, c, s, pred);
    due_results.push_back(typed ? want : pred);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      // a quarter of bursts run straight on, giving stretches with no idling
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // result side: every transfer is held against the oldest outstanding result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_taken++;
      got_res = '{ok_o, char_out_o, cursor_o, length_o};
      if (due_results.size() == 0) begin
        report_mismatch("result with none outstanding, cursor", cursor_o, 0);
      end else begin
        want_res = due_results.pop_front();
        if (got_res.ok !== want_res.ok) report_mismatch("ok", got_res.ok, want_res.ok);
        if (got_res.ch !== want_res.ch) report_mismatch("char_out", got_res.ch, want_res.ch);
        if (got_res.cur !== want_res.cur) report_mismatch("cursor", got_res.cur, want_res.cur);
        if (got_res.len !== want_res.len) report_mismatch("length", got_res.len, want_res.len);
      end
    end
  end

  // receiver: stall pattern drawn anew whenever its random tick count runs out, plus one long hold-off
  initial begin
    int rx_mode;
    int rx_tick;
    int rx_hold;
    bit hold_done;
    logic [1:0] rx_phase;
    rx_mode = 0;
    rx_tick = 0;
    rx_hold = 0;
    hold_done = 1'b0;
    rx_phase = '0;
    forever begin
      @(posedge clk_i);
      // long hold-off once the run is under way: the block fills and stalls its input
      if (!hold_done && res_taken >= 300) begin
        hold_done = 1'b1;
        rx_hold = 400;
      end
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        if (rx_tick == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_tick = $urandom_range(20, 120);
        end
        rx_tick--;
        rx_phase++;
        case (rx_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (rx_phase == 2'd0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus: directed table, then random editing sessions
  initial begin
    int r;
    int n;
    int mode;
    int mode_left;
    int pick;
    logic [KindW-1:0] k;
    logic [CharW-1:0] c;
    logic [StepW-1:0] s;
    mode = 0;
    mode_left = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      for (n = 0; n < int'(dir_tab[r].reps); n++) begin
        send_cmd(dir_tab[r].kind, dir_tab[r].ch, dir_tab[r].step, dir_tab[r].typed,
                 dir_tab[r].want);
      end
    end

    for (n = 0; n < RandItems; n++) begin
      // sessions: fill the line, drain it, browse it, or plain noise
      if (mode_left == 0) begin
        pick = $urandom_range(0, 9);
        mode = (pick < 4) ? 0 : (pick < 6) ? 1 : (pick < 9) ? 2 : 3;
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      pick = $urandom_range(0, 99);
      case (mode)
        0: k = (pick < 60) ? KindInsert : (pick < 75) ? KindMove :
               (pick < 90) ? KindGet : (pick < 95) ? KindBackspace : KindDelete;
        1: k = (pick < 35) ? KindBackspace : (pick < 70) ? KindDelete :
               (pick < 85) ? KindMove : (pick < 95) ? KindGet : KindInsert;
        2: k = (pick < 40) ? KindMove : (pick < 80) ? KindGet :
               (pick < 90) ? KindInsert : KindDelete;
        default: k = KindW'($urandom_range(0, 7));
      endcase
      c = (mode == 3) ? CharW'($urandom_range(0, 255)) : CharW'($urandom_range(1, 255));
      pick = $urandom_range(0, 9);
      // small steps walk the line, the rest reach both ends and beyond
      if (pick < 5) s = StepW'($urandom_range(0, 8) - 4);
      else if (pick < 8) s = StepW'($urandom_range(0, 128) - 64);
      else s = StepW'($urandom_range(0, 255));
      send_cmd(k, c, s, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    // allow for any stray transfer after the last expected one
    repeat (Capacity + 10) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
